// File: sv/ers_pkg.sv
// Shared codes, widths and transaction types for the elevator request scheduler.
`timescale 1ns / 1ps

package ers_pkg;

	localparam int FLOORS_DEF = 4;

	localparam int OP_W    = 2;
	localparam int FLOOR_W = 2;
	localparam int DIR_W   = 2;
	localparam int BTN_W   = 2;
	localparam int MV_W    = 2;
	localparam int BTN_N   = 3;

	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OP_W-1:0] OP_EVAL  = 2'd2;

	localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
	localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
	localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

	localparam logic [BTN_W-1:0] BTN_UP   = 2'd0;
	localparam logic [BTN_W-1:0] BTN_DOWN = 2'd1;
	localparam logic [BTN_W-1:0] BTN_CAB  = 2'd2;

	localparam logic [MV_W-1:0] MV_IDLE = 2'd0;
	localparam logic [MV_W-1:0] MV_MOVE = 2'd1;
	localparam logic [MV_W-1:0] MV_DOOR = 2'd2;

	// bit positions inside one floor entry
	localparam int BIT_UP   = 0;
	localparam int BIT_DOWN = 1;
	localparam int BIT_CAB  = 2;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [FLOOR_W-1:0] cur_floor;
		logic [DIR_W-1:0]   dir;
		logic [FLOOR_W-1:0] btn_floor;
		logic [BTN_W-1:0]   btn;
		logic               value;
	} item_t;

	typedef struct packed {
		logic             here;
		logic             above;
		logic             below;
		logic             bit_read;
		logic [BTN_N-1:0] cur_bits;
	} status_t;

endpackage

// File: sv/elevator_request_scheduler_core.sv
// Elevator request scheduler top level: input register, table update, result register.
// The request is held in the input register; res_valid comes from the result register, loaded on advance.
// One transaction per cycle while the result is not stalled; table update and reduction are combinational.
// A stalled result holds the input stage, which then stalls the request side.
// Reset (arst_n low, asynchronous) clears all request bits and both valid flags.
`timescale 1ns / 1ps

module elevator_request_scheduler_core import ers_pkg::*; #(
	parameter int FLOORS = FLOORS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [OP_W-1:0]    operation,
	input  logic [FLOOR_W-1:0] cur_floor,
	input  logic [DIR_W-1:0]   dir,
	input  logic [FLOOR_W-1:0] btn_floor,
	input  logic [BTN_W-1:0]   btn,
	input  logic               value,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [DIR_W-1:0]   next_dir,
	output logic [MV_W-1:0]    movement,
	output logic               should_stop,
	output logic               clear_immediately,
	output logic               request_here,
	output logic               request_above,
	output logic               request_below,
	output logic               bit_read
);

	item_t            item_s1;
	logic             valid_s1;
	logic             adv;
	status_t          st;
	logic [DIR_W-1:0] nd;
	logic [MV_W-1:0]  mv;
	logic             stop;
	logic             clr;

	logic             res_valid_q;
	logic [DIR_W-1:0] next_dir_q;
	logic [MV_W-1:0]  movement_q;
	logic             should_stop_q;
	logic             clear_imm_q;
	logic             here_q;
	logic             above_q;
	logic             below_q;
	logic             bit_read_q;

	assign adv       = valid_s1 && (!res_valid_q || res_ready);
	assign req_ready = !valid_s1 || adv;

	ers_table #(.FLOORS(FLOORS)) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.upd_en (adv),
		.item   (item_s1),
		.status (st)
	);

	always_comb begin
		nd = DIR_STOP;
		mv = MV_IDLE;
		case (item_s1.dir)
			DIR_UP: begin
				if (st.above) begin
					nd = DIR_UP;   mv = MV_MOVE;
				end else if (st.here) begin
					nd = DIR_DOWN; mv = MV_DOOR;
				end else if (st.below) begin
					nd = DIR_DOWN; mv = MV_MOVE;
				end
			end
			DIR_DOWN: begin
				if (st.below) begin
					nd = DIR_DOWN; mv = MV_MOVE;
				end else if (st.here) begin
					nd = DIR_UP;   mv = MV_DOOR;
				end else if (st.above) begin
					nd = DIR_UP;   mv = MV_MOVE;
				end
			end
			DIR_STOP: begin
				if (st.here) begin
					nd = DIR_STOP; mv = MV_DOOR;
				end else if (st.above) begin
					nd = DIR_UP;   mv = MV_MOVE;
				end else if (st.below) begin
					nd = DIR_DOWN; mv = MV_MOVE;
				end
			end
			default: begin
				nd = DIR_STOP;
				mv = MV_IDLE;
			end
		endcase
	end

	always_comb begin
		case (item_s1.dir)
			DIR_DOWN: stop = st.cur_bits[BIT_DOWN] || st.cur_bits[BIT_CAB] || !st.below;
			DIR_UP:   stop = st.cur_bits[BIT_UP] || st.cur_bits[BIT_CAB] || !st.above;
			default:  stop = 1'b1;
		endcase
	end

	assign clr = (item_s1.cur_floor == item_s1.btn_floor) &&
		((item_s1.dir == DIR_UP && item_s1.btn == BTN_UP) ||
		 (item_s1.dir == DIR_DOWN && item_s1.btn == BTN_DOWN) ||
		 item_s1.dir == DIR_STOP || item_s1.btn == BTN_CAB);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (req_ready)
				valid_s1 <= req_valid;
			if (adv)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1.operation <= operation;
			item_s1.cur_floor <= cur_floor;
			item_s1.dir       <= dir;
			item_s1.btn_floor <= btn_floor;
			item_s1.btn       <= btn;
			item_s1.value     <= value;
		end
		if (adv) begin
			next_dir_q    <= nd;
			movement_q    <= mv;
			should_stop_q <= stop;
			clear_imm_q   <= clr;
			here_q        <= st.here;
			above_q       <= st.above;
			below_q       <= st.below;
			bit_read_q    <= st.bit_read;
		end
	end

	assign res_valid         = res_valid_q;
	assign next_dir          = next_dir_q;
	assign movement          = movement_q;
	assign should_stop       = should_stop_q;
	assign clear_immediately = clear_imm_q;
	assign request_here      = here_q;
	assign request_above     = above_q;
	assign request_below     = below_q;
	assign bit_read          = bit_read_q;

	a_door_needs_here: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && movement == MV_DOOR |-> request_here)
		else $error("door open without a request at the car floor");

	a_up_needs_above: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && movement == MV_MOVE && next_dir == DIR_UP |-> request_above)
		else $error("moving up with nothing requested above");

	a_down_needs_below: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && movement == MV_MOVE && next_dir == DIR_DOWN |-> request_below)
		else $error("moving down with nothing requested below");

	a_idle_is_stop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && movement == MV_IDLE |-> next_dir == DIR_STOP)
		else $error("idle result with a travel direction");

endmodule

// File: sv/ers_table.sv
// Request table: per-floor request bits, update and here/above/below reduction.
`timescale 1ns / 1ps

module ers_table import ers_pkg::*; #(
	parameter int FLOORS = FLOORS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    upd_en,
	input  item_t   item,
	output status_t status
);

	logic [BTN_N-1:0]  bits_q [FLOORS];
	logic [BTN_N-1:0]  bits_n [FLOORS];
	logic [FLOORS-1:0] cf_hit;
	logic [FLOORS-1:0] bf_hit;
	logic [FLOORS-1:0] above_m;
	logic [FLOORS-1:0] below_m;
	logic [FLOORS-1:0] occ_q;
	logic [FLOORS-1:0] occ_n;
	logic              above_old;
	logic              below_old;
	logic [BTN_N-1:0]  cur_bits;
	logic [BTN_N-1:0]  bf_bits;
	logic              bit_sel;

	// clear by direction; above/below exclude this floor so old table is fine
	function automatic logic [BTN_N-1:0] clear_dir(
		input logic [BTN_N-1:0] b,
		input logic [DIR_W-1:0] d,
		input logic             above,
		input logic             below
	);
		logic [BTN_N-1:0] r;
		r = b;
		r[BIT_CAB] = 1'b0;
		case (d)
			DIR_UP: begin
				if (!above && !b[BIT_UP])
					r[BIT_DOWN] = 1'b0;
				r[BIT_UP] = 1'b0;
			end
			DIR_DOWN: begin
				if (!below && !b[BIT_DOWN])
					r[BIT_UP] = 1'b0;
				r[BIT_DOWN] = 1'b0;
			end
			default: begin
				r[BIT_UP]   = 1'b0;
				r[BIT_DOWN] = 1'b0;
			end
		endcase
		return r;
	endfunction

	for (genvar k = 0; k < FLOORS; k++) begin : g_floor
		assign cf_hit[k]  = (32'(item.cur_floor) == k);
		assign bf_hit[k]  = (32'(item.btn_floor) == k);
		assign above_m[k] = (k > 32'(item.cur_floor));
		assign below_m[k] = (k < 32'(item.cur_floor));
		assign occ_q[k]   = |bits_q[k];
		assign occ_n[k]   = |bits_n[k];
	end

	assign above_old = |(occ_q & above_m);
	assign below_old = |(occ_q & below_m);

	always_comb begin
		logic [BTN_N-1:0] nb;
		for (int k = 0; k < FLOORS; k++) begin
			nb = bits_q[k];
			if (item.operation == OP_CLEAR && cf_hit[k]) begin
				nb = clear_dir(bits_q[k], item.dir, above_old, below_old);
			end else if (item.operation == OP_WRITE && bf_hit[k]) begin
				case (item.btn)
					BTN_UP:   nb[BIT_UP]   = item.value;
					BTN_DOWN: nb[BIT_DOWN] = item.value;
					BTN_CAB:  nb[BIT_CAB]  = item.value;
					default:  nb = bits_q[k];
				endcase
			end
			bits_n[k] = nb;
		end
	end

	// floors outside the table never hit, so their bits read as zero
	always_comb begin
		cur_bits = '0;
		bf_bits  = '0;
		for (int k = 0; k < FLOORS; k++) begin
			cur_bits = cur_bits | (cf_hit[k] ? bits_n[k] : '0);
			bf_bits  = bf_bits  | (bf_hit[k] ? bits_n[k] : '0);
		end
	end

	always_comb begin
		case (item.btn)
			BTN_UP:   bit_sel = bf_bits[BIT_UP];
			BTN_DOWN: bit_sel = bf_bits[BIT_DOWN];
			BTN_CAB:  bit_sel = bf_bits[BIT_CAB];
			default:  bit_sel = 1'b0;
		endcase
	end

	assign status.here     = |(occ_n & cf_hit);
	assign status.above    = |(occ_n & above_m);
	assign status.below    = |(occ_n & below_m);
	assign status.bit_read = bit_sel;
	assign status.cur_bits = cur_bits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < FLOORS; k++)
				bits_q[k] <= '0;
		end else if (upd_en) begin
			for (int k = 0; k < FLOORS; k++)
				bits_q[k] <= bits_n[k];
		end
	end

	a_no_update_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!upd_en |=> (occ_q == $past(occ_q)))
		else $error("request table changed without an update");

	a_clear_drops_cab: assert property (@(posedge clk) disable iff (!arst_n)
		(item.operation == OP_CLEAR) |-> !status.cur_bits[BIT_CAB])
		else $error("cab request left at floor after clear");

	a_write_reads_back: assert property (@(posedge clk) disable iff (!arst_n)
		(item.operation == OP_WRITE && item.btn == BTN_CAB &&
		 32'(item.btn_floor) < FLOORS) |-> (status.bit_read == item.value))
		else $error("written cab bit does not read back");

endmodule

// File: test/tb_elevator_request_scheduler_core.sv
// Self-checking testbench for the elevator request scheduler core.
`timescale 1ns / 1ps

module tb_elevator_request_scheduler_core;
	import ers_pkg::*;

	localparam int FLOORS = FLOORS_DEF;
	localparam int RANDOM_CALLS = 400;
	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD = 300;
	localparam int DRAIN_CYCLES = 10;

	// codes outside the defined sets
	localparam logic [OP_W-1:0]  OP_BAD  = 2'd3;
	localparam logic [DIR_W-1:0] DIR_BAD = 2'd3;
	localparam logic [BTN_W-1:0] BTN_BAD = 2'd3;

	typedef struct packed {
		logic [DIR_W-1:0] next_dir;
		logic [MV_W-1:0]  movement;
		logic             should_stop;
		logic             clear_immediately;
		logic             request_here;
		logic             request_above;
		logic             request_below;
		logic             bit_read;
	} dispatch_t;

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_ready;
	logic [OP_W-1:0]    operation;
	logic [FLOOR_W-1:0] cur_floor;
	logic [DIR_W-1:0]   dir;
	logic [FLOOR_W-1:0] btn_floor;
	logic [BTN_W-1:0]   btn;
	logic               value;
	logic               res_valid;
	logic               res_ready;
	logic [DIR_W-1:0]   next_dir;
	logic [MV_W-1:0]    movement;
	logic               should_stop;
	logic               clear_immediately;
	logic               request_here;
	logic               request_above;
	logic               request_below;
	logic               bit_read;

	elevator_request_scheduler_core #(.FLOORS(FLOORS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.operation(operation),
		.cur_floor(cur_floor),
		.dir(dir),
		.btn_floor(btn_floor),
		.btn(btn),
		.value(value),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.next_dir(next_dir),
		.movement(movement),
		.should_stop(should_stop),
		.clear_immediately(clear_immediately),
		.request_here(request_here),
		.request_above(request_above),
		.request_below(request_below),
		.bit_read(bit_read)
	);

	// predictor copy of the request table
	logic [BTN_N-1:0] floor_calls [FLOORS];

	item_t     call_q[$];
	dispatch_t dispatch_q[$];
	int        total_calls;
	int        calls_offered;
	int        calls_taken;
	int        mismatches;
	int        idle_cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic calls_beyond(int f, bit upward);
		logic found;
		found = 1'b0;
		for (int k = 0; k < FLOORS; k++) begin
			if ((upward ? (k > f) : (k < f)) && (|floor_calls[k]))
				found = 1'b1;
		end
		return found;
	endfunction

	// applies the transaction to the table, then evaluates on the updated table
	function automatic dispatch_t predict_dispatch(item_t it);
		dispatch_t r;
		int        f;
		logic      here;
		logic      above;
		logic      below;
		f = it.cur_floor;
		case (it.operation)
			OP_WRITE: begin
				if (it.btn <= BTN_CAB)
					floor_calls[it.btn_floor][it.btn] = it.value;
			end
			OP_CLEAR: begin
				floor_calls[f][BIT_CAB] = 1'b0;
				if (it.dir == DIR_UP) begin
					if (!calls_beyond(f, 1'b1) && !floor_calls[f][BIT_UP])
						floor_calls[f][BIT_DOWN] = 1'b0;
					floor_calls[f][BIT_UP] = 1'b0;
				end else if (it.dir == DIR_DOWN) begin
					if (!calls_beyond(f, 1'b0) && !floor_calls[f][BIT_DOWN])
						floor_calls[f][BIT_UP] = 1'b0;
					floor_calls[f][BIT_DOWN] = 1'b0;
				end else begin
					floor_calls[f][BIT_UP] = 1'b0;
					floor_calls[f][BIT_DOWN] = 1'b0;
				end
			end
			default: ;
		endcase

		here = |floor_calls[f];
		above = calls_beyond(f, 1'b1);
		below = calls_beyond(f, 1'b0);

		r.next_dir = DIR_STOP;
		r.movement = MV_IDLE;
		case (it.dir)
			DIR_UP: begin
				if (above) begin
					r.next_dir = DIR_UP;   r.movement = MV_MOVE;
				end else if (here) begin
					r.next_dir = DIR_DOWN; r.movement = MV_DOOR;
				end else if (below) begin
					r.next_dir = DIR_DOWN; r.movement = MV_MOVE;
				end
			end
			DIR_DOWN: begin
				if (below) begin
					r.next_dir = DIR_DOWN; r.movement = MV_MOVE;
				end else if (here) begin
					r.next_dir = DIR_UP;   r.movement = MV_DOOR;
				end else if (above) begin
					r.next_dir = DIR_UP;   r.movement = MV_MOVE;
				end
			end
			DIR_STOP: begin
				if (here) begin
					r.next_dir = DIR_STOP; r.movement = MV_DOOR;
				end else if (above) begin
					r.next_dir = DIR_UP;   r.movement = MV_MOVE;
				end else if (below) begin
					r.next_dir = DIR_DOWN; r.movement = MV_MOVE;
				end
			end
			default: ;
		endcase

		if (it.dir == DIR_DOWN)
			r.should_stop = floor_calls[f][BIT_DOWN] | floor_calls[f][BIT_CAB] | !below;
		else if (it.dir == DIR_UP)
			r.should_stop = floor_calls[f][BIT_UP] | floor_calls[f][BIT_CAB] | !above;
		else
			r.should_stop = 1'b1;

		r.clear_immediately = (it.cur_floor == it.btn_floor) &&
			((it.dir == DIR_UP && it.btn == BTN_UP) ||
			 (it.dir == DIR_DOWN && it.btn == BTN_DOWN) ||
			 it.dir == DIR_STOP || it.btn == BTN_CAB);
		r.request_here = here;
		r.request_above = above;
		r.request_below = below;
		r.bit_read = (it.btn <= BTN_CAB) ? floor_calls[it.btn_floor][it.btn] : 1'b0;
		return r;
	endfunction

	task automatic queue_call(logic [OP_W-1:0] op, logic [FLOOR_W-1:0] cf,
			logic [DIR_W-1:0] d, logic [FLOOR_W-1:0] bf, logic [BTN_W-1:0] b, logic v);
		item_t it;
		it.operation = op;
		it.cur_floor = cf;
		it.dir = d;
		it.btn_floor = bf;
		it.btn = b;
		it.value = v;
		call_q.push_back(it);
	endtask

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// request driver: bursts of random length with random gaps
	always @(negedge clk) begin : drive_calls
		item_t nxt;
		int    gap_left;
		int    burst_left;
		if (arst_n && !(req_valid && calls_taken != calls_offered)) begin
			if (gap_left > 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (call_q.size() != 0) begin
				nxt = call_q.pop_front();
				operation <= nxt.operation;
				cur_floor <= nxt.cur_floor;
				dir <= nxt.dir;
				btn_floor <= nxt.btn_floor;
				btn <= nxt.btn;
				value <= nxt.value;
				req_valid <= 1'b1;
				calls_offered++;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left--;
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end : drive_calls

	// result receiver: changing stall modes plus one long hold-off
	always @(negedge clk) begin : take_results
		int hold_left;
		bit long_hold_done;
		int mode_left;
		int stall_mode;
		int beat;
		beat++;
		if (hold_left > 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else if (!long_hold_done && calls_taken >= 200) begin
			// hold long enough that the pipeline fills and req_ready drops
			long_hold_done = 1'b1;
			hold_left = LONG_HOLD;
			res_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 80);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0: res_ready <= 1'b1;
				1: res_ready <= 1'($urandom_range(0, 1));
				2: res_ready <= ($urandom_range(0, 7) == 0);
				default: res_ready <= (beat % 5) < 2;
			endcase
		end
	end : take_results

	// prediction on accepted requests, then comparison of accepted results
	always @(posedge clk) begin : score
		dispatch_t want;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				dispatch_q.push_back(predict_dispatch({operation, cur_floor, dir,
					btn_floor, btn, value}));
				calls_taken++;
			end
			if (res_valid && res_ready) begin
				if (dispatch_q.size() == 0) begin
					$display("%0t: unexpected result transaction, expected none, actual %0d/%0d",
						$time, next_dir, movement);
					mismatches++;
				end else begin
					want = dispatch_q.pop_front();
					check_field("next_dir", want.next_dir, next_dir);
					check_field("movement", want.movement, movement);
					check_field("should_stop", want.should_stop, should_stop);
					check_field("clear_immediately", want.clear_immediately,
						clear_immediately);
					check_field("request_here", want.request_here, request_here);
					check_field("request_above", want.request_above, request_above);
					check_field("request_below", want.request_below, request_below);
					check_field("bit_read", want.bit_read, bit_read);
				end
			end
		end
	end : score

	always @(posedge clk) begin
		if (arst_n && !(req_valid && req_ready) && !(res_valid && res_ready))
			idle_cycles++;
		else
			idle_cycles = 0;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
			$display("[elevator_request_scheduler_core] ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		logic [FLOOR_W-1:0] car;
		logic [DIR_W-1:0] heading;
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		res_ready = 1'b0;
		operation = OP_EVAL;
		cur_floor = '0;
		dir = DIR_STOP;
		btn_floor = '0;
		btn = BTN_UP;
		value = 1'b0;
		calls_offered = 0;
		calls_taken = 0;
		mismatches = 0;
		idle_cycles = 0;
		for (int k = 0; k < FLOORS; k++)
			floor_calls[k] = '0;

		// directed: empty table, clearing by direction, unknown codes, extremes
		queue_call(OP_EVAL,  2'd0, DIR_STOP, 2'd0, BTN_UP,   1'b0);
		queue_call(OP_WRITE, 2'd0, DIR_UP,   2'd3, BTN_CAB,  1'b1);
		queue_call(OP_WRITE, 2'd0, DIR_UP,   2'd0, BTN_UP,   1'b1);
		queue_call(OP_WRITE, 2'd0, DIR_UP,   2'd0, BTN_DOWN, 1'b1);
		queue_call(OP_CLEAR, 2'd0, DIR_UP,   2'd0, BTN_UP,   1'b0);
		queue_call(OP_EVAL,  2'd0, DIR_DOWN, 2'd0, BTN_DOWN, 1'b0);
		queue_call(OP_WRITE, 2'd3, DIR_UP,   2'd3, BTN_DOWN, 1'b1);
		queue_call(OP_CLEAR, 2'd3, DIR_UP,   2'd3, BTN_DOWN, 1'b0);
		queue_call(OP_WRITE, 2'd3, DIR_DOWN, 2'd3, BTN_UP,   1'b1);
		queue_call(OP_WRITE, 2'd3, DIR_DOWN, 2'd3, BTN_DOWN, 1'b1);
		queue_call(OP_CLEAR, 2'd3, DIR_DOWN, 2'd3, BTN_UP,   1'b0);
		queue_call(OP_WRITE, 2'd0, DIR_DOWN, 2'd0, BTN_UP,   1'b1);
		queue_call(OP_CLEAR, 2'd0, DIR_DOWN, 2'd0, BTN_UP,   1'b0);
		queue_call(OP_CLEAR, 2'd0, DIR_STOP, 2'd0, BTN_CAB,  1'b0);
		queue_call(OP_WRITE, 2'd2, DIR_STOP, 2'd2, BTN_BAD,  1'b1);
		queue_call(OP_EVAL,  2'd2, DIR_BAD,  2'd2, BTN_CAB,  1'b1);
		queue_call(OP_EVAL,  2'd2, DIR_BAD,  2'd2, BTN_BAD,  1'b0);
		queue_call(OP_BAD,   2'd1, DIR_UP,   2'd3, BTN_UP,   1'b1);
		queue_call(OP_WRITE, 2'd1, DIR_UP,   2'd3, BTN_UP,   1'b0);
		queue_call(OP_WRITE, 2'd1, DIR_STOP, 2'd1, BTN_CAB,  1'b1);
		queue_call(OP_EVAL,  2'd1, DIR_STOP, 2'd1, BTN_CAB,  1'b0);
		queue_call(OP_CLEAR, 2'd3, DIR_BAD,  2'd0, BTN_DOWN, 1'b1);
		queue_call(OP_EVAL,  2'd3, DIR_DOWN, 2'd3, BTN_DOWN, 1'b0);

		// random: service rounds of button presses, a look, an optional arrival clear, a look, at times a random call
		total_calls = call_q.size() + RANDOM_CALLS;
		while (call_q.size() < total_calls) begin
			car = FLOOR_W'($urandom_range(0, FLOORS - 1));
			heading = ($urandom_range(0, 15) == 0) ? DIR_BAD : DIR_W'($urandom_range(0, 2));
			repeat ($urandom_range(1, 4))
				queue_call(OP_WRITE, car, heading,
					FLOOR_W'($urandom_range(0, FLOORS - 1)),
					($urandom_range(0, 15) == 0) ? BTN_BAD : BTN_W'($urandom_range(0, 2)),
					$urandom_range(0, 9) < 7);
			queue_call(OP_EVAL, car, heading, FLOOR_W'($urandom_range(0, FLOORS - 1)),
				BTN_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 3) != 0)
				queue_call(OP_CLEAR, car, heading, car, BTN_W'($urandom_range(0, 3)),
					1'($urandom_range(0, 1)));
			queue_call(($urandom_range(0, 7) == 0) ? OP_BAD : OP_EVAL, car, heading,
				FLOOR_W'($urandom_range(0, FLOORS - 1)), BTN_W'($urandom_range(0, 3)),
				1'($urandom_range(0, 1)));
			if ($urandom_range(0, 5) == 0)
				queue_call(OP_W'($urandom_range(0, 3)), FLOOR_W'($urandom_range(0, 3)),
					DIR_W'($urandom_range(0, 3)), FLOOR_W'($urandom_range(0, 3)),
					BTN_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
		end
		total_calls = call_q.size();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (calls_taken != total_calls)
			@(posedge clk);
		while (dispatch_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[elevator_request_scheduler_core] OK");
		else
			$display("[elevator_request_scheduler_core] ERROR");
		$finish;
	end : stimulus

endmodule
